@@ hdl/bdq_pkg.sv @@
// Shared types and constants for the bounded deque.
`default_nettype none
package bdq_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_PEEK_FRONT = 3'd3,
        OP_EMPTY_Q    = 3'd4,
        OP_DUMP       = 3'd5
    } t_opcode;

    localparam int unsigned WORD_W = 32;

    typedef logic signed [WORD_W-1:0] t_word;

    localparam t_word WORD_NONE = -32'sd1;
    localparam t_word WORD_ONE  = 32'sd1;
    localparam t_word WORD_ZERO = 32'sd0;

endpackage
`default_nettype wire

@@ hdl/bounded_deque_with_dump.sv @@
// Bounded deque of signed words in a circular RAM, with front-to-back dump.
// Pop, peek, empty query and overflow/no-entry words appear the cycle after the
// command is taken; pushes give no result. One command is taken per cycle while busy
// is low; a dump reads the stored words front to back, one RAM read each, with busy
// high while the words after the front are read. The receiver cannot stall. Reset
// (synchronous, active low) empties the deque; RAM contents are not cleared.
`default_nettype none
module bounded_deque_with_dump #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [2:0]           i_opcode,
    input  wire logic signed [31:0]   i_push_value,
    output logic                      o_busy,
    output logic                      o_valid,
    output logic signed [31:0]        o_data,
    output logic                      o_no_entry,
    output logic                      o_overflow,
    output logic                      o_last
);
    import bdq_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    // Word storage: one write port, one registered read port.
    t_word mem [DEPTH];
    t_word r_rd_data;

    // Deque pointers and fill level.
    logic [AW-1:0] r_front, n_front;
    logic [AW-1:0] r_back,  n_back;
    logic [CW-1:0] r_count, n_count;

    // Dump walk: next read address and words still to read.
    logic [AW-1:0] r_dump_ptr, n_dump_ptr;
    logic [CW-1:0] r_dump_left, n_dump_left;

    // Result register; data comes from RAM or from a fixed word.
    logic  r_valid, n_valid;
    logic  r_from_mem, n_from_mem;
    logic  r_no_entry, n_no_entry;
    logic  r_overflow, n_overflow;
    logic  r_last, n_last;
    t_word r_fixed, n_fixed;

    logic          accept;
    logic          we;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          is_empty;
    logic          is_full;
    logic [AW-1:0] front_inc;
    logic [AW-1:0] front_dec;
    logic [AW-1:0] back_inc;
    logic [AW-1:0] dump_inc;

    assign o_busy   = (r_dump_left != '0);
    assign accept   = i_start && !o_busy;
    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == CNT_FULL);

    assign front_inc = (r_front == PTR_LAST) ? '0 : r_front + AW'(1);
    assign front_dec = (r_front == '0) ? PTR_LAST : r_front - AW'(1);
    assign back_inc  = (r_back == PTR_LAST) ? '0 : r_back + AW'(1);
    assign dump_inc  = (r_dump_ptr == PTR_LAST) ? '0 : r_dump_ptr + AW'(1);

    // During a dump the walk pointer drives the read port; otherwise the front.
    assign rd_addr = o_busy ? r_dump_ptr : r_front;

    always_comb begin
        n_front     = r_front;
        n_back      = r_back;
        n_count     = r_count;
        n_dump_ptr  = r_dump_ptr;
        n_dump_left = r_dump_left;
        n_valid     = 1'b0;
        n_from_mem  = 1'b0;
        n_no_entry  = 1'b0;
        n_overflow  = 1'b0;
        n_last      = 1'b1;
        n_fixed     = WORD_ZERO;
        we          = 1'b0;
        wr_addr     = r_back;

        if (o_busy) begin
            // Dump walk: one RAM read per cycle, last flag on the back word.
            n_valid     = 1'b1;
            n_from_mem  = 1'b1;
            n_last      = (r_dump_left == CNT_ONE);
            n_dump_ptr  = dump_inc;
            n_dump_left = r_dump_left - CNT_ONE;
        end else if (accept) begin
            unique case (t_opcode'(i_opcode))
                OP_PUSH_FRONT, OP_PUSH_BACK: begin
                    if (is_full) begin
                        n_valid    = 1'b1;
                        n_overflow = 1'b1;
                    end else begin
                        we      = 1'b1;
                        n_count = r_count + CNT_ONE;
                        if (t_opcode'(i_opcode) == OP_PUSH_FRONT) begin
                            wr_addr = front_dec;
                            n_front = front_dec;
                        end else begin
                            wr_addr = r_back;
                            n_back  = back_inc;
                        end
                    end
                end
                OP_POP_FRONT, OP_PEEK_FRONT: begin
                    n_valid = 1'b1;
                    if (is_empty) begin
                        n_no_entry = 1'b1;
                        n_fixed    = WORD_NONE;
                    end else begin
                        n_from_mem = 1'b1;
                        if (t_opcode'(i_opcode) == OP_POP_FRONT) begin
                            n_front = front_inc;
                            n_count = r_count - CNT_ONE;
                        end
                    end
                end
                OP_EMPTY_Q: begin
                    n_valid = 1'b1;
                    n_fixed = is_empty ? WORD_ONE : WORD_ZERO;
                end
                OP_DUMP: begin
                    n_valid = 1'b1;
                    if (is_empty) begin
                        n_no_entry = 1'b1;
                        n_fixed    = WORD_NONE;
                    end else begin
                        // Front is read this cycle; the walk covers the rest.
                        n_from_mem  = 1'b1;
                        n_last      = (r_count == CNT_ONE);
                        n_dump_ptr  = front_inc;
                        n_dump_left = r_count - CNT_ONE;
                    end
                end
                default: begin
                    n_valid = 1'b0;
                end
            endcase
        end
    end

    // RAM: write and registered read.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= i_push_value;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_back      <= '0;
            r_count     <= '0;
            r_dump_left <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_front     <= n_front;
            r_back      <= n_back;
            r_count     <= n_count;
            r_dump_left <= n_dump_left;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dump_ptr <= n_dump_ptr;
        r_from_mem <= n_from_mem;
        r_no_entry <= n_no_entry;
        r_overflow <= n_overflow;
        r_last     <= n_last;
        r_fixed    <= n_fixed;
    end

    assign o_valid    = r_valid;
    assign o_data     = r_from_mem ? r_rd_data : r_fixed;
    assign o_no_entry = r_no_entry;
    assign o_overflow = r_overflow;
    assign o_last     = r_last;

endmodule
`default_nettype wire
